@@ hw/rtl/ighp_pkg.sv @@
// Shared types, codes and constants of the indexed grid min-heap.
`timescale 1ns / 1ps
package ighp_pkg;

   // Default geometry and key width.
   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;
   localparam int DEF_KEY_BITS    = 32;

   // Fixed field widths of the channels.
   localparam int COORD_BITS     = 6;
   localparam int CELL_BITS      = 2 * COORD_BITS;
   localparam int PKEY_BITS      = 32;
   localparam int COUNT_OUT_BITS = 13;

   // Request codes.
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD_REQ,
      DP_FETCH_POS,
      DP_APPEND,
      DP_UP_READ,
      DP_UP_STEP,
      DP_DOWN_READ,
      DP_DOWN_STEP,
      DP_PLACE,
      DP_POP_READ,
      DP_POP_TAKE,
      DP_CLEAR,
      DP_RESPOND,
      DP_INIT_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       in_grid;
      logic       present;
      logic       full;
      logic       empty;
      logic       last_one;
      logic       at_root;
      logic       up_move;
      logic       has_child;
      logic       down_move;
      logic       sweep_done;
   } dp_stat_type;

endpackage

@@ hw/rtl/ighp_channels.sv @@
// Request and response channel interfaces of the indexed grid min-heap.
`timescale 1ns / 1ps
interface ighp_req_if import ighp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [COORD_BITS-1:0]       cell_x;
   logic [COORD_BITS-1:0]       cell_y;
   logic signed [PKEY_BITS-1:0] cell_key;

   modport source(output valid, req_type, cell_x, cell_y, cell_key, input ready);
   modport sink(input valid, req_type, cell_x, cell_y, cell_key, output ready);
endinterface

interface ighp_rsp_if import ighp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        popped_valid;
   logic [COORD_BITS-1:0]       popped_x;
   logic [COORD_BITS-1:0]       popped_y;
   logic signed [PKEY_BITS-1:0] popped_key;
   logic                        heap_empty;
   logic [COUNT_OUT_BITS-1:0]   entry_count;
   logic [1:0]                  status;

   modport source(output valid, popped_valid, popped_x, popped_y, popped_key,
                  heap_empty, entry_count, status, input ready);
   modport sink(input valid, popped_valid, popped_x, popped_y, popped_key,
                heap_empty, entry_count, status, output ready);
endinterface

@@ hw/rtl/ighp_dp.sv @@
// Datapath of the indexed grid min-heap: heap memory, position map and sift registers.
`timescale 1ns / 1ps
module ighp_dp import ighp_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_stat_type                 stat,
   input  logic [1:0]                  req_type,
   input  logic [COORD_BITS-1:0]       cell_x,
   input  logic [COORD_BITS-1:0]       cell_y,
   input  logic signed [PKEY_BITS-1:0] cell_key,
   output logic                        popped_valid,
   output logic [COORD_BITS-1:0]       popped_x,
   output logic [COORD_BITS-1:0]       popped_y,
   output logic signed [PKEY_BITS-1:0] popped_key,
   output logic                        heap_empty,
   output logic [COUNT_OUT_BITS-1:0]   entry_count,
   output logic [1:0]                  status
);

   localparam int CAP      = GRID_WIDTH * GRID_HEIGHT;
   localparam int HW       = $clog2(CAP);
   localparam int CNTW     = $clog2(CAP + 1);
   localparam int KW       = (KEY_BITS < PKEY_BITS) ? KEY_BITS : PKEY_BITS;
   localparam int IW       = HW + 2;
   localparam int PM_DEPTH = 2 ** CELL_BITS;

   typedef struct packed {
      logic [CELL_BITS-1:0] cell_id;
      logic [KW-1:0]        key;
   } entry_type;

   function automatic logic key_less(input logic [KW-1:0] a, input logic [KW-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   // Heap array and per-cell position map.
   entry_type       heap_mem [CAP];
   logic [HW-1:0]   pm_mem [PM_DEPTH];

   entry_type            rd_a_ff, rd_b_ff;
   logic [HW-1:0]        pm_rd_ff;
   logic [HW-1:0]        cur_idx_ff;
   entry_type            cur_ff;
   logic [CNTW-1:0]      count_ff;
   logic [CELL_BITS-1:0] sweep_ff;
   logic [1:0]           kind_ff;
   logic                 in_grid_ff;
   logic                 pop_valid_ff;
   entry_type            pop_ff;

   logic                        rsp_pv_ff;
   logic [CELL_BITS-1:0]        rsp_cell_ff;
   logic signed [PKEY_BITS-1:0] rsp_key_ff;
   logic                        rsp_empty_ff;
   logic [COUNT_OUT_BITS-1:0]   rsp_count_ff;
   logic [1:0]                  rsp_status_ff;

   logic [HW-1:0]        parent;
   logic [IW-1:0]        left_w, right_w, count_w;
   logic                 has_r, pick_right, up_move, down_move;
   entry_type            sel;
   logic [HW-1:0]        sel_idx;
   logic [CNTW+COUNT_OUT_BITS-1:0] cnt_ext;

   logic [HW-1:0]        ra_addr, rb_addr, hw_addr;
   logic                 hw_en;
   entry_type            hw_data;
   logic [CELL_BITS-1:0] pm_raddr, pm_waddr;
   logic                 pm_wen;
   logic [HW-1:0]        pm_wdata;

   // Tree neighbors of the current position and sift decisions.
   always_comb begin
      parent     = HW'((cur_idx_ff - HW'(1)) >> 1);
      left_w     = {1'b0, cur_idx_ff, 1'b1};
      right_w    = left_w + IW'(1);
      count_w    = IW'(count_ff);
      has_r      = right_w < count_w;
      pick_right = has_r && key_less(rd_b_ff.key, rd_a_ff.key);
      sel        = pick_right ? rd_b_ff : rd_a_ff;
      sel_idx    = pick_right ? right_w[HW-1:0] : left_w[HW-1:0];
      up_move    = key_less(cur_ff.key, rd_a_ff.key);
      down_move  = key_less(sel.key, cur_ff.key);
      cnt_ext    = {{COUNT_OUT_BITS{1'b0}}, count_ff};
   end

   always_comb begin
      stat.req_kind   = kind_ff;
      stat.in_grid    = in_grid_ff;
      stat.present    = (IW'(cur_idx_ff) < count_w) && (rd_a_ff.cell_id == cur_ff.cell_id);
      stat.full       = count_ff >= CNTW'(CAP);
      stat.empty      = count_ff == '0;
      stat.last_one   = count_ff == CNTW'(1);
      stat.at_root    = cur_idx_ff == '0;
      stat.up_move    = up_move;
      stat.has_child  = left_w < count_w;
      stat.down_move  = down_move;
      stat.sweep_done = sweep_ff == '1;
   end

   // Memory addresses and write enables for the current operation.
   always_comb begin
      ra_addr  = cur_idx_ff;
      rb_addr  = cur_idx_ff;
      hw_en    = 1'b0;
      hw_addr  = cur_idx_ff;
      hw_data  = cur_ff;
      pm_raddr = cur_ff.cell_id;
      pm_wen   = 1'b0;
      pm_waddr = cur_ff.cell_id;
      pm_wdata = cur_idx_ff;
      case (cmd.op)
         DP_LOAD_REQ: begin
            pm_raddr = {cell_y, cell_x};
         end
         DP_FETCH_POS: begin
            ra_addr = pm_rd_ff;
         end
         DP_UP_READ: begin
            ra_addr = parent;
         end
         DP_UP_STEP: begin
            hw_en    = up_move;
            hw_data  = rd_a_ff;
            pm_wen   = up_move;
            pm_waddr = rd_a_ff.cell_id;
         end
         DP_DOWN_READ: begin
            ra_addr = left_w[HW-1:0];
            rb_addr = right_w[HW-1:0];
         end
         DP_DOWN_STEP: begin
            hw_en    = down_move;
            hw_data  = sel;
            pm_wen   = down_move;
            pm_waddr = sel.cell_id;
         end
         DP_PLACE: begin
            hw_en  = 1'b1;
            pm_wen = 1'b1;
         end
         DP_POP_READ: begin
            ra_addr = '0;
            rb_addr = HW'(count_ff - CNTW'(1));
         end
         DP_INIT_WRITE: begin
            pm_wen   = 1'b1;
            pm_waddr = sweep_ff;
            pm_wdata = '0;
         end
         default: begin
         end
      endcase
   end

   // Heap memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (hw_en) begin
         heap_mem[hw_addr] <= hw_data;
      end
      rd_a_ff <= heap_mem[ra_addr];
      rd_b_ff <= heap_mem[rb_addr];
   end

   // Position map: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (pm_wen) begin
         pm_mem[pm_waddr] <= pm_wdata;
      end
      pm_rd_ff <= pm_mem[pm_raddr];
   end

   // Entry count and the clearing sweep pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         case (cmd.op)
            DP_APPEND:     count_ff <= count_ff + CNTW'(1);
            DP_POP_TAKE:   count_ff <= count_ff - CNTW'(1);
            DP_CLEAR:      count_ff <= '0;
            DP_INIT_WRITE: sweep_ff <= sweep_ff + CELL_BITS'(1);
            default: begin
            end
         endcase
      end
   end

   // Working entry, popped entry and the response register.
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD_REQ: begin
            kind_ff        <= req_type;
            cur_ff.cell_id <= {cell_y, cell_x};
            cur_ff.key     <= cell_key[KW-1:0];
            in_grid_ff     <= (32'(cell_x) < 32'(GRID_WIDTH)) &&
                              (32'(cell_y) < 32'(GRID_HEIGHT));
            pop_valid_ff   <= 1'b0;
            pop_ff         <= '0;
         end
         DP_FETCH_POS: cur_idx_ff <= pm_rd_ff;
         DP_APPEND:    cur_idx_ff <= count_ff[HW-1:0];
         DP_UP_STEP: begin
            if (up_move) begin
               cur_idx_ff <= parent;
            end
         end
         DP_DOWN_STEP: begin
            if (down_move) begin
               cur_idx_ff <= sel_idx;
            end
         end
         DP_POP_TAKE: begin
            pop_valid_ff <= 1'b1;
            pop_ff       <= rd_a_ff;
            cur_ff       <= rd_b_ff;
            cur_idx_ff   <= '0;
         end
         DP_RESPOND: begin
            rsp_pv_ff     <= pop_valid_ff;
            rsp_cell_ff   <= pop_ff.cell_id;
            rsp_key_ff    <= PKEY_BITS'(signed'(pop_ff.key));
            rsp_empty_ff  <= count_ff == '0;
            rsp_count_ff  <= cnt_ext[COUNT_OUT_BITS-1:0];
            rsp_status_ff <= cmd.rsp_status;
         end
         default: begin
         end
      endcase
   end

   assign popped_valid = rsp_pv_ff;
   assign popped_x     = rsp_cell_ff[COORD_BITS-1:0];
   assign popped_y     = rsp_cell_ff[CELL_BITS-1:COORD_BITS];
   assign popped_key   = rsp_key_ff;
   assign heap_empty   = rsp_empty_ff;
   assign entry_count  = rsp_count_ff;
   assign status       = rsp_status_ff;

endmodule

@@ hw/rtl/ighp_ctrl.sv @@
// Controller state machine of the indexed grid min-heap.
`timescale 1ns / 1ps
module ighp_ctrl import ighp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_CHECK,
      S_UP_TEST,
      S_UP_STEP,
      S_DOWN_TEST,
      S_DOWN_STEP,
      S_PLACE,
      S_POP_TAKE,
      S_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   // Next state and the datapath operation for this cycle.
   always_comb begin
      state_in       = state_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd.op         = DP_NOP;
      cmd.rsp_status = rsp_status_ff;
      case (state_ff)
         S_INIT: begin
            cmd.op = DP_INIT_WRITE;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op        = DP_LOAD_REQ;
               rsp_status_in = STAT_OK;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.req_kind)
               REQ_INSERT: begin
                  if (stat.in_grid) begin
                     cmd.op   = DP_FETCH_POS;
                     state_in = S_CHECK;
                  end else begin
                     state_in = S_RESPOND;
                  end
               end
               REQ_POP: begin
                  if (stat.empty) begin
                     rsp_status_in = STAT_POP_EMPTY;
                     state_in      = S_RESPOND;
                  end else begin
                     cmd.op   = DP_POP_READ;
                     state_in = S_POP_TAKE;
                  end
               end
               REQ_CLEAR: begin
                  cmd.op   = DP_CLEAR;
                  state_in = S_RESPOND;
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_CHECK: begin
            if (stat.present) begin
               state_in = S_UP_TEST;
            end else if (stat.full) begin
               rsp_status_in = STAT_FULL;
               state_in      = S_RESPOND;
            end else begin
               cmd.op   = DP_APPEND;
               state_in = S_UP_TEST;
            end
         end
         S_UP_TEST: begin
            if (stat.at_root) begin
               state_in = S_DOWN_TEST;
            end else begin
               cmd.op   = DP_UP_READ;
               state_in = S_UP_STEP;
            end
         end
         S_UP_STEP: begin
            cmd.op   = DP_UP_STEP;
            state_in = stat.up_move ? S_UP_TEST : S_DOWN_TEST;
         end
         S_DOWN_TEST: begin
            if (stat.has_child) begin
               cmd.op   = DP_DOWN_READ;
               state_in = S_DOWN_STEP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DOWN_STEP: begin
            cmd.op   = DP_DOWN_STEP;
            state_in = stat.down_move ? S_DOWN_TEST : S_PLACE;
         end
         S_PLACE: begin
            cmd.op   = DP_PLACE;
            state_in = S_RESPOND;
         end
         S_POP_TAKE: begin
            cmd.op   = DP_POP_TAKE;
            state_in = stat.last_one ? S_RESPOND : S_DOWN_TEST;
         end
         S_RESPOND: begin
            // Load the output register once the previous transaction has left.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STAT_OK;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/indexed_grid_min_heap.sv @@
// Top level of the indexed grid min-heap: controller, datapath and checks.
//
// Usage: each request transaction on req_bus is an insert (new cell or new key
// for a present cell), a pop of the minimum, or a clear. Every request gives
// exactly one response transaction on rsp_bus with the popped cell, the entry
// count after the request and a status code.
// One request is in work at a time. A clear, a pop of an empty heap or an
// ignored request needs no sift. An insert or a pop may sift through the heap
// one level at a time, and each level needs a read of the heap memory and a
// compare before the next level can be chosen.
// After reset the block sweeps the 4096-entry position map, one entry a
// cycle, before req_bus.ready first rises.
// The response sits in an output register; a new request is accepted while
// it waits, and the block holds its next response until rsp_bus.ready takes
// the previous one.
`timescale 1ns / 1ps
module indexed_grid_min_heap import ighp_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input logic        clock,
   input logic        reset,
   ighp_req_if.sink   req_bus,
   ighp_rsp_if.source rsp_bus
);

   localparam int CAP = GRID_WIDTH * GRID_HEIGHT;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ighp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ighp_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .KEY_BITS    (KEY_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_bus.req_type),
      .cell_x       (req_bus.cell_x),
      .cell_y       (req_bus.cell_y),
      .cell_key     (req_bus.cell_key),
      .popped_valid (rsp_bus.popped_valid),
      .popped_x     (rsp_bus.popped_x),
      .popped_y     (rsp_bus.popped_y),
      .popped_key   (rsp_bus.popped_key),
      .heap_empty   (rsp_bus.heap_empty),
      .entry_count  (rsp_bus.entry_count),
      .status       (rsp_bus.status)
   );

   // The reported count never exceeds the heap capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (32'(rsp_bus.entry_count) <= CAP))
      else $error("entry count above capacity");

   // The empty flag agrees with the reported count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.heap_empty == (rsp_bus.entry_count == '0)))
      else $error("empty flag disagrees with count");

   // A pop of an empty heap returns no cell and leaves the heap empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == STAT_POP_EMPTY)
         |-> (!rsp_bus.popped_valid && rsp_bus.heap_empty))
      else $error("empty pop returned a cell");

   // A new request is taken only when the controller issues its load.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (cmd.op == DP_LOAD_REQ))
      else $error("request accepted without load");

endmodule

@@ tb/indexed_grid_min_heap_test.sv @@
// Self-checking testbench of the indexed grid min-heap with a heap predictor.
`timescale 1ns / 1ps

// Scoreboard: a predictor of the heap and a queue of expected responses.
class heap_scoreboard;
   typedef struct packed {
      logic        popped_valid;
      logic [5:0]  popped_x;
      logic [5:0]  popped_y;
      logic [31:0] popped_key;
      logic        heap_empty;
      logic [12:0] entry_count;
      logic [1:0]  status;
   } heap_rsp_type;

   localparam int CAPACITY = 4096;

   logic [11:0]        slot_cell [CAPACITY];
   logic signed [31:0] slot_key [CAPACITY];
   int                 cell_slot [CAPACITY];
   bit                 cell_live [CAPACITY];
   int                 fill;
   heap_rsp_type       pending_rsps [$];
   int                 mismatch_count;

   function new();
      fill = 0;
      mismatch_count = 0;
      foreach (cell_live[i]) cell_live[i] = 0;
   endfunction

   function void swap_slots(int i, int j);
      logic [11:0]        c;
      logic signed [31:0] k;
      c = slot_cell[i]; k = slot_key[i];
      slot_cell[i] = slot_cell[j]; slot_key[i] = slot_key[j];
      slot_cell[j] = c; slot_key[j] = k;
      cell_slot[slot_cell[i]] = i;
      cell_slot[slot_cell[j]] = j;
   endfunction

   function void bubble_up(int i);
      int p;
      while (i != 0) begin
         p = (i - 1) / 2;
         if (!(slot_key[i] < slot_key[p])) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function void bubble_down(int i);
      int l, s;
      forever begin
         l = 2 * i + 1;
         if (l >= fill) break;
         s = l;
         if (l + 1 < fill && slot_key[l+1] < slot_key[l]) s = l + 1;
         if (!(slot_key[s] < slot_key[i])) break;
         swap_slots(s, i);
         i = s;
      end
   endfunction

   // Apply one accepted request to the predicted heap and queue its response.
   function void note_request(logic [1:0] kind, logic [5:0] x, logic [5:0] y,
                              logic signed [31:0] key);
      heap_rsp_type r;
      int           cell_num;
      r = '0;
      cell_num = {y, x};
      if (kind == ighp_pkg::REQ_INSERT) begin
         if (cell_live[cell_num]) begin
            slot_key[cell_slot[cell_num]] = key;
            bubble_up(cell_slot[cell_num]);
            bubble_down(cell_slot[cell_num]);
         end else if (fill >= CAPACITY) begin
            r.status = ighp_pkg::STAT_FULL;
         end else begin
            slot_cell[fill] = 12'(cell_num);
            slot_key[fill] = key;
            cell_slot[cell_num] = fill;
            cell_live[cell_num] = 1;
            fill++;
            bubble_up(fill - 1);
         end
      end else if (kind == ighp_pkg::REQ_POP) begin
         if (fill == 0) begin
            r.status = ighp_pkg::STAT_POP_EMPTY;
         end else begin
            r.popped_valid = 1;
            r.popped_x = slot_cell[0][5:0];
            r.popped_y = slot_cell[0][11:6];
            r.popped_key = slot_key[0];
            cell_live[slot_cell[0]] = 0;
            fill--;
            if (fill > 0) begin
               slot_cell[0] = slot_cell[fill];
               slot_key[0] = slot_key[fill];
               cell_slot[slot_cell[0]] = 0;
               bubble_down(0);
            end
         end
      end else if (kind == ighp_pkg::REQ_CLEAR) begin
         fill = 0;
         foreach (cell_live[i]) cell_live[i] = 0;
      end
      r.heap_empty = (fill == 0);
      r.entry_count = 13'(fill);
      pending_rsps.push_back(r);
   endfunction

   // Compare one accepted response with the oldest expectation.
   function void check_response(heap_rsp_type got);
      heap_rsp_type want;
      if (pending_rsps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Unexpected response %p", got);
         return;
      end
      want = pending_rsps.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Response mismatch: expected %p, actual %p", want, got);
      end
   endfunction
endclass

module indexed_grid_min_heap_test;
   import ighp_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   // Request code with no defined operation.
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic clock;
   logic reset;
   int   idle_cycles;
   bit   stim_done;
   heap_scoreboard board;

   ighp_req_if req_bus ();
   ighp_rsp_if rsp_bus ();

   indexed_grid_min_heap u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   // Clock generation.
   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Monitor both channels at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(req_bus.req_type, req_bus.cell_x, req_bus.cell_y,
                               req_bus.cell_key);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_response({rsp_bus.popped_valid, rsp_bus.popped_x,
                                  rsp_bus.popped_y, rsp_bus.popped_key,
                                  rsp_bus.heap_empty, rsp_bus.entry_count,
                                  rsp_bus.status});
      end
   end

   // Watchdog on cycles with no transaction.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver stall pattern: phases of steady acceptance and of random stalls.
   always @(posedge clock) begin
      int phase;
      phase = int'(($time / 5000) % 3);
      if (reset) rsp_bus.ready <= 0;
      else if (stim_done || phase == 0) rsp_bus.ready <= 1;
      else if (phase == 1) rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      else rsp_bus.ready <= ($urandom_range(0, 9) < 3);
   end

   // Send one request and wait for its acceptance.
   task automatic send_request(logic [1:0] kind, logic [5:0] x, logic [5:0] y,
                               logic [31:0] key);
      req_bus.valid <= 1;
      req_bus.req_type <= kind;
      req_bus.cell_x <= x;
      req_bus.cell_y <= y;
      req_bus.cell_key <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid for a number of cycles between bursts.
   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 7) << 16;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int burst;
      int sent;
      int small_cells;
      board = new();
      stim_done = 0;
      idle_cycles = 0;
      reset = 1;
      req_bus.valid = 0;
      req_bus.req_type = REQ_INSERT;
      req_bus.cell_x = 0;
      req_bus.cell_y = 0;
      req_bus.cell_key = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed part: empty pop, extremes, ties, key updates, unused code, clear.
      send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_INSERT, 63, 63, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 0, 0, 32'h8000_0000);
      send_request(REQ_INSERT, 1, 0, 32'h0001_0000);
      send_request(REQ_INSERT, 2, 0, 32'h0001_0000);
      send_request(REQ_INSERT, 3, 0, 32'h0001_0000);
      send_request(REQ_INSERT, 63, 63, 32'hFFFF_0000);
      send_request(REQ_INSERT, 0, 0, 32'h7FFF_0000);
      send_request(REQ_SPARE, 42, 21, 32'h1234_5678);
      repeat (4) send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_CLEAR, 0, 0, 0);
      send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_INSERT, 5, 5, 32'h0000_0001);
      send_request(REQ_CLEAR, 0, 0, 0);
      send_request(REQ_INSERT, 5, 5, 32'h0000_0002);
      send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_POP, 0, 0, 0);

      // Random part: mostly fill-and-drain sequences, some noise and clears.
      sent = 0;
      while (sent < 750) begin
         small_cells = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            case ($urandom_range(0, 19))
               0: send_request(REQ_CLEAR, 6'($urandom), 6'($urandom), $urandom);
               1: send_request(REQ_SPARE, 6'($urandom), 6'($urandom), $urandom);
               2, 3, 4, 5, 6, 7:
                  send_request(REQ_POP, 6'($urandom), 6'($urandom), $urandom);
               default:
                  if (small_cells)
                     send_request(REQ_INSERT, 6'($urandom_range(0, 3)),
                                  6'($urandom_range(0, 3)), pick_key());
                  else
                     send_request(REQ_INSERT, 6'($urandom), 6'($urandom), pick_key());
            endcase
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
      end
      req_bus.valid <= 0;
      stim_done = 1;

      while (board.pending_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/ighp_pkg.sv
hw/rtl/ighp_channels.sv
hw/rtl/ighp_dp.sv
hw/rtl/ighp_ctrl.sv
hw/rtl/indexed_grid_min_heap.sv
tb/indexed_grid_min_heap_test.sv
